@@ design/dentab_pkg.sv @@
`default_nettype none

package dentab_pkg;

    // Table geometry
    localparam int CAPACITY   = 16;
    localparam int NAME_BYTES = 8;
    localparam int LIST_LIMIT = 16;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LCNT_W = $clog2(LIST_LIMIT + 1);

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int NAME_W   = 64;
    localparam int INODE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int COUNT_MAX = 31;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [LCNT_W-1:0]   lcnt_t;
    typedef logic [NAME_W-1:0]   name_t;
    typedef logic [INODE_W-1:0]  inode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LIST  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Status codes
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // Keep the first NAME_BYTES bytes up to the first zero byte
    function automatic name_t normalize_name(input name_t raw);
        name_t res;
        logic  stop;
        res  = '0;
        stop = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            if (raw[8*k +: 8] == 8'h00)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                res[8*k +: 8] = raw[8*k +: 8];
            end
        end
        return res;
    endfunction

    // Entry count as reported, saturating at the field maximum
    function automatic count_t sat_count(input cnt_t c);
        count_t res;
        if (32'(c) > COUNT_MAX)
        begin
            res = count_t'(COUNT_MAX);
        end
        else
        begin
            res = count_t'(c);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/directory_entry_table_core.sv @@
`default_nettype none

// Directory entry table: CAPACITY slots of (name word, inode number).
// Input channel (in_valid/in_stall) carries func, entry_name, inode_number;
// an item transfers when in_valid is high and in_stall is low. Output channel
// (out_valid/out_stall) carries status, entry_count, has_entry, listed_name,
// listed_inode and last; a result transfers when out_valid is high and
// out_stall is low. One request is worked on at a time; in_stall stays high
// from the transfer of a request until its final result has transferred, and
// the next request can transfer in the cycle after that.
// Write: the name is compared against one slot per cycle through a single
// registered read port and one comparator; the scan ends early on a hit,
// and an empty name answers without a scan.
// List: slots are stepped one per cycle until the next used one, which is then
// read out through the load state; each listed entry is one result, the final one
// carries last. Clear and unused codes answer in the cycle after the transfer.
// A stalled result holds its fields until taken. Reset clears the slot valid
// bits and the entry count at once, so the table is empty with no sweep.

module directory_entry_table_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [dentab_pkg::FUNC_W-1:0] func,
    input  wire dentab_pkg::name_t             entry_name,
    input  wire dentab_pkg::inode_t            inode_number,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output dentab_pkg::status_t                status,
    output dentab_pkg::count_t                 entry_count,
    output logic                               has_entry,
    output dentab_pkg::name_t                  listed_name,
    output dentab_pkg::inode_t                 listed_inode,
    output logic                               last
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_WR_SCAN   = 3'd1;
    localparam logic [2:0] ST_LIST_SEEK = 3'd2;
    localparam logic [2:0] ST_LIST_LOAD = 3'd3;
    localparam logic [2:0] ST_OUT       = 3'd4;

    localparam int CAP = dentab_pkg::CAPACITY;

    // Control state
    logic [2:0]              state_reg, state_next;
    logic [CAP-1:0]          valid_bits_reg, valid_bits_next;
    dentab_pkg::cnt_t        used_count_reg, used_count_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    issue_on_reg, issue_on_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    free_found_reg, free_found_next;
    logic                    list_more_reg, list_more_next;
    dentab_pkg::idx_t        ptr_reg, ptr_next;

    // Working payload
    dentab_pkg::name_t       name_reg, name_next;
    dentab_pkg::inode_t      inode_reg, inode_next;
    dentab_pkg::idx_t        rd_idx_reg, rd_idx_next;
    logic                    rd_vld_reg, rd_vld_next;
    dentab_pkg::idx_t        free_idx_reg, free_idx_next;
    dentab_pkg::lcnt_t       listed_cnt_reg, listed_cnt_next;
    logic                    last_pend_reg, last_pend_next;

    // Result register
    dentab_pkg::status_t     out_status_reg, out_status_next;
    dentab_pkg::count_t      out_count_reg, out_count_next;
    logic                    out_has_reg, out_has_next;
    dentab_pkg::name_t       out_name_reg, out_name_next;
    dentab_pkg::inode_t      out_inode_reg, out_inode_next;
    logic                    out_last_reg, out_last_next;

    // Slot storage
    dentab_pkg::name_t       name_mem [CAP];
    dentab_pkg::inode_t      inode_mem [CAP];
    dentab_pkg::name_t       rd_name_reg;
    dentab_pkg::inode_t      rd_inode_reg;
    logic                    mem_we_name;
    logic                    mem_we_inode;
    dentab_pkg::idx_t        mem_wr_addr;
    dentab_pkg::name_t       mem_wr_name;
    dentab_pkg::inode_t      mem_wr_inode;

    logic                    in_xfer;
    logic                    out_xfer;
    logic                    load_plain;
    dentab_pkg::status_t     plain_status;
    dentab_pkg::cnt_t        plain_count;
    dentab_pkg::name_t       norm_name;
    logic [CAP-1:0]          above_mask;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    assign norm_name = dentab_pkg::normalize_name(entry_name);

    // Slots above the pointer, for the last-entry lookahead
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            above_mask[i] = (i > int'(ptr_reg));
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        valid_bits_next = valid_bits_reg;
        used_count_next = used_count_reg;
        out_valid_next  = out_valid_reg;
        issue_on_next   = issue_on_reg;
        rd_pend_next    = rd_pend_reg;
        free_found_next = free_found_reg;
        list_more_next  = list_more_reg;
        ptr_next        = ptr_reg;
        name_next       = name_reg;
        inode_next      = inode_reg;
        rd_idx_next     = rd_idx_reg;
        rd_vld_next     = rd_vld_reg;
        free_idx_next   = free_idx_reg;
        listed_cnt_next = listed_cnt_reg;
        last_pend_next  = last_pend_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_has_next    = out_has_reg;
        out_name_next   = out_name_reg;
        out_inode_next  = out_inode_reg;
        out_last_next   = out_last_reg;
        mem_we_name     = 1'b0;
        mem_we_inode    = 1'b0;
        mem_wr_addr     = ptr_reg;
        mem_wr_name     = name_reg;
        mem_wr_inode    = inode_reg;
        load_plain      = 1'b0;
        plain_status    = dentab_pkg::STATUS_OK;
        plain_count     = used_count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (func)
                        dentab_pkg::FUNC_WRITE:
                        begin
                            name_next  = norm_name;
                            inode_next = inode_number;
                            if (norm_name == '0)
                            begin
                                load_plain   = 1'b1;
                                plain_status = dentab_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                ptr_next        = '0;
                                issue_on_next   = 1'b1;
                                rd_pend_next    = 1'b0;
                                free_found_next = 1'b0;
                                state_next      = ST_WR_SCAN;
                            end
                        end
                        dentab_pkg::FUNC_LIST:
                        begin
                            if (valid_bits_reg == '0)
                            begin
                                load_plain = 1'b1;
                            end
                            else
                            begin
                                ptr_next        = '0;
                                listed_cnt_next = '0;
                                state_next      = ST_LIST_SEEK;
                            end
                        end
                        dentab_pkg::FUNC_CLEAR:
                        begin
                            valid_bits_next = '0;
                            used_count_next = '0;
                            load_plain      = 1'b1;
                            plain_count     = '0;
                        end
                        default:
                        begin
                            load_plain = 1'b1;
                        end
                    endcase
                end
            end

            ST_WR_SCAN:
            begin
                // Issue one slot read per cycle, tracking the lowest free slot
                rd_pend_next = issue_on_reg;
                if (issue_on_reg)
                begin
                    rd_idx_next = ptr_reg;
                    rd_vld_next = valid_bits_reg[ptr_reg];
                    if (!valid_bits_reg[ptr_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = ptr_reg;
                    end
                    if (ptr_reg == dentab_pkg::idx_t'(CAP - 1))
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + dentab_pkg::idx_t'(1);
                    end
                end
                // Compare the slot read last cycle
                if (rd_pend_reg)
                begin
                    if (rd_vld_reg && (rd_name_reg == name_reg))
                    begin
                        mem_we_inode = 1'b1;
                        mem_wr_addr  = rd_idx_reg;
                        load_plain   = 1'b1;
                    end
                    else if (rd_idx_reg == dentab_pkg::idx_t'(CAP - 1))
                    begin
                        load_plain = 1'b1;
                        if (free_found_reg)
                        begin
                            mem_we_name                   = 1'b1;
                            mem_we_inode                  = 1'b1;
                            mem_wr_addr                   = free_idx_reg;
                            valid_bits_next[free_idx_reg] = 1'b1;
                            used_count_next = used_count_reg + dentab_pkg::cnt_t'(1);
                            plain_count     = used_count_reg + dentab_pkg::cnt_t'(1);
                        end
                        else
                        begin
                            plain_status = dentab_pkg::STATUS_FULL;
                        end
                    end
                end
            end

            ST_LIST_SEEK:
            begin
                // Step to the next used slot; its read is issued in this cycle
                if (valid_bits_reg[ptr_reg])
                begin
                    last_pend_next =
                        (listed_cnt_reg == dentab_pkg::lcnt_t'(dentab_pkg::LIST_LIMIT - 1))
                        || ((valid_bits_reg & above_mask) == '0);
                    state_next = ST_LIST_LOAD;
                end
                else
                begin
                    ptr_next = ptr_reg + dentab_pkg::idx_t'(1);
                end
            end

            ST_LIST_LOAD:
            begin
                out_valid_next  = 1'b1;
                out_status_next = dentab_pkg::STATUS_OK;
                out_count_next  = dentab_pkg::sat_count(used_count_reg);
                out_has_next    = 1'b1;
                out_name_next   = rd_name_reg;
                out_inode_next  = rd_inode_reg;
                out_last_next   = last_pend_reg;
                list_more_next  = !last_pend_reg;
                state_next      = ST_OUT;
            end

            ST_OUT:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    if (list_more_reg)
                    begin
                        ptr_next        = ptr_reg + dentab_pkg::idx_t'(1);
                        listed_cnt_next = listed_cnt_reg + dentab_pkg::lcnt_t'(1);
                        state_next      = ST_LIST_SEEK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Single-result answer with empty listed fields
        if (load_plain)
        begin
            out_valid_next  = 1'b1;
            out_status_next = plain_status;
            out_count_next  = dentab_pkg::sat_count(plain_count);
            out_has_next    = 1'b0;
            out_name_next   = '0;
            out_inode_next  = '0;
            out_last_next   = 1'b1;
            list_more_next  = 1'b0;
            state_next      = ST_OUT;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_bits_reg <= '0;
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            issue_on_reg   <= 1'b0;
            rd_pend_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            list_more_reg  <= 1'b0;
            ptr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_bits_reg <= valid_bits_next;
            used_count_reg <= used_count_next;
            out_valid_reg  <= out_valid_next;
            issue_on_reg   <= issue_on_next;
            rd_pend_reg    <= rd_pend_next;
            free_found_reg <= free_found_next;
            list_more_reg  <= list_more_next;
            ptr_reg        <= ptr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        name_reg       <= name_next;
        inode_reg      <= inode_next;
        rd_idx_reg     <= rd_idx_next;
        rd_vld_reg     <= rd_vld_next;
        free_idx_reg   <= free_idx_next;
        listed_cnt_reg <= listed_cnt_next;
        last_pend_reg  <= last_pend_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_has_reg    <= out_has_next;
        out_name_reg   <= out_name_next;
        out_inode_reg  <= out_inode_next;
        out_last_reg   <= out_last_next;
    end

    // Slot memory: one write port, one registered read port at the pointer
    always_ff @(posedge clk)
    begin
        if (mem_we_name)
        begin
            name_mem[mem_wr_addr] <= mem_wr_name;
        end
        if (mem_we_inode)
        begin
            inode_mem[mem_wr_addr] <= mem_wr_inode;
        end
        rd_name_reg  <= name_mem[ptr_reg];
        rd_inode_reg <= inode_mem[ptr_reg];
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign entry_count  = out_count_reg;
    assign has_entry    = out_has_reg;
    assign listed_name  = out_name_reg;
    assign listed_inode = out_inode_reg;
    assign last         = out_last_reg;

    // Entry count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_bits_reg) == int'(used_count_reg))
        else $error("entry count differs from number of valid slots");

    // A result is only presented from the output state
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_OUT))
        else $error("result valid outside output state");

    // Listed entries always report ok
    a_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_has_reg) |-> (out_status_reg == dentab_pkg::STATUS_OK))
        else $error("listed entry with error status");

    // A lookup never runs on an empty name
    a_scan_name: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR_SCAN) |-> (name_reg != '0))
        else $error("lookup running with empty name");

endmodule

`default_nettype wire
